// ===== sv/h2r_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// h2r_pkg: shared types and constants for the hsv to rgb converter
// Pixel structs, hue sector codes and the fixed-point constants used by the
// rounded divisions in the pipeline.
// ---------------------------------------------------------------------------
package h2r_pkg;

	typedef struct packed {
		logic [8:0] hue_deg;
		logic [7:0] sat;
		logic [7:0] val;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// hue sectors of 60 degrees each
	localparam logic [2:0] SECT_R_Y = 3'd0;
	localparam logic [2:0] SECT_Y_G = 3'd1;
	localparam logic [2:0] SECT_G_C = 3'd2;
	localparam logic [2:0] SECT_C_B = 3'd3;
	localparam logic [2:0] SECT_B_M = 3'd4;
	localparam logic [2:0] SECT_M_R = 3'd5;

	localparam logic [8:0] HUE_LIMIT  = 9'd360;
	localparam logic [5:0] SECTOR_DEG = 6'd60;
	localparam logic [7:0] FULL_SCALE = 8'd255;

	// floor term: round(v*(255-s)/255) = (x + 127) / 255
	localparam logic [15:0] FLOOR_BIAS = 16'd127;
	// secondary term: round(v*d/15300) = (m + 7650) / 15300
	localparam logic [13:0] SEC_HALF = 14'd15300;
	localparam logic [21:0] SEC_BIAS = 22'd7650;
	localparam logic [21:0] SEC_DIV  = 22'd15300;
	// reciprocal of 15300 scaled by 2^36, rounded down
	localparam logic [22:0] SEC_RECIP = 23'd4491469;

	typedef struct packed {
		logic       err;
		logic [2:0] sector;
		logic [5:0] term;
	} h2r_sector_t;

endpackage
`default_nettype wire

// ===== sv/h2r_sector.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// h2r_sector: hue sector split
// Splits the hue into its 60 degree sector and picks the multiplier for the
// secondary term (rising or falling with the offset inside the sector).
// ---------------------------------------------------------------------------
module h2r_sector (
	input  wire logic [8:0]          hue_deg,
	output h2r_pkg::h2r_sector_t     info
);

	logic [8:0] base;
	logic [2:0] sector;
	logic [5:0] offset;

	always_comb begin
		if (hue_deg >= 9'd300) begin
			sector = h2r_pkg::SECT_M_R;
			base   = 9'd300;
		end else if (hue_deg >= 9'd240) begin
			sector = h2r_pkg::SECT_B_M;
			base   = 9'd240;
		end else if (hue_deg >= 9'd180) begin
			sector = h2r_pkg::SECT_C_B;
			base   = 9'd180;
		end else if (hue_deg >= 9'd120) begin
			sector = h2r_pkg::SECT_G_C;
			base   = 9'd120;
		end else if (hue_deg >= 9'd60) begin
			sector = h2r_pkg::SECT_Y_G;
			base   = 9'd60;
		end else begin
			sector = h2r_pkg::SECT_R_Y;
			base   = 9'd0;
		end
	end

	// offset is only meaningful below the hue limit
	assign offset = 6'(hue_deg - base);

	always_comb begin
		info.err    = (hue_deg >= h2r_pkg::HUE_LIMIT);
		info.sector = sector;
		// the secondary term falls with the offset in odd sectors, rises in even ones
		info.term   = sector[0] ? offset : 6'(h2r_pkg::SECTOR_DEG - offset);
	end

endmodule
`default_nettype wire

// ===== sv/hsv_to_rgb_integer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// hsv_to_rgb_integer: 8-bit hsv to rgb pixel converter
// Five-stage pipeline with rounded integer divisions.
// ---------------------------------------------------------------------------
// Usage:
//   Drive a pixel on hsv and pulse start. busy is always low, so a pixel is
//   taken on every clock edge at which start is high: one pixel per cycle.
//   The converted pixel appears on rgb when it leaves the last stage register,
//   s5, with done high for exactly one cycle.
//   Pixels leave in the order they came.
//   A hue of 360 or more gives pure red (255, 0, 0).
//   Stages: hue sector split, the two products v*(255-s) and s*term,
//   the product v*(15300 - s*term) with the first floor estimate,
//   the reciprocal multiply for /15300 with the floor correction, and the
//   final correction with channel ordering.
//   The receiver cannot hold off results; there is no back pressure, and a
//   new pixel can be taken while earlier ones are still in the pipeline.
//   Reset clears the valid bits of all stages, so no done pulse follows
//   reset until a new pixel is taken; pixels in flight are dropped.
// ---------------------------------------------------------------------------
module hsv_to_rgb_integer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire h2r_pkg::hsv_t  hsv,
	output logic                done,
	output h2r_pkg::rgb_t       rgb
);

	h2r_pkg::h2r_sector_t sect_info;

	// stage registers
	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic        err_s1, err_s2, err_s3, err_s4;
	logic [2:0]  sector_s1, sector_s2, sector_s3, sector_s4;
	logic [5:0]  term_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  val_s1, val_s2, val_s3, val_s4;
	logic [15:0] fmul_s2;
	logic [13:0] smul_s2;
	logic [21:0] prod_s3;
	logic [15:0] fy_s3;
	logic [7:0]  fq_s3;
	logic [21:0] w_s4;
	logic [7:0]  sq_s4;
	logic [7:0]  flo_s4;
	h2r_pkg::rgb_t rgb_s5;

	// combinational per stage
	logic [13:0] sdiff;
	logic [15:0] fy;
	logic [15:0] fsum;
	logic [15:0] frem;
	logic [21:0] w;
	logic [44:0] wk;
	logic [21:0] srem;
	logic [7:0]  sec;

	assign busy = 1'b0;

	h2r_sector u_sector (
		.hue_deg (hsv.hue_deg),
		.info    (sect_info)
	);

	always_comb begin
		sdiff = h2r_pkg::SEC_HALF - smul_s2;
		fy    = fmul_s2 + h2r_pkg::FLOOR_BIAS;
		fsum  = fy + (fy >> 8);
		frem  = fy_s3 - 16'(fq_s3) * 16'd255;
		w     = prod_s3 + h2r_pkg::SEC_BIAS;
		wk    = 45'(w) * 45'(h2r_pkg::SEC_RECIP);
		srem  = w_s4 - 22'(sq_s4) * h2r_pkg::SEC_DIV;
		sec   = (srem >= h2r_pkg::SEC_DIV) ? sq_s4 + 8'd1 : sq_s4;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		// s1: sector split
		err_s1    <= sect_info.err;
		sector_s1 <= sect_info.sector;
		term_s1   <= sect_info.term;
		sat_s1    <= hsv.sat;
		val_s1    <= hsv.val;

		// s2: v*(255-s) and s*term
		err_s2    <= err_s1;
		sector_s2 <= sector_s1;
		val_s2    <= val_s1;
		fmul_s2   <= 16'(val_s1) * 16'(h2r_pkg::FULL_SCALE - sat_s1);
		smul_s2   <= 14'(sat_s1) * 14'(term_s1);

		// s3: v*(15300 - s*term), floor estimate of /255 (low by at most one)
		err_s3    <= err_s2;
		sector_s3 <= sector_s2;
		val_s3    <= val_s2;
		prod_s3   <= 22'(val_s2) * 22'(sdiff);
		fy_s3     <= fy;
		fq_s3     <= fsum[15:8];

		// s4: reciprocal estimate of /15300, floor correction
		err_s4    <= err_s3;
		sector_s4 <= sector_s3;
		val_s4    <= val_s3;
		w_s4      <= w;
		sq_s4     <= wk[43:36];
		flo_s4    <= (frem >= 16'd255) ? fq_s3 + 8'd1 : fq_s3;

		// s5: secondary correction and channel order
		if (err_s4) begin
			rgb_s5 <= '{red: 8'd255, green: 8'd0, blue: 8'd0};
		end else begin
			case (sector_s4)
				h2r_pkg::SECT_R_Y: rgb_s5 <= '{red: val_s4, green: sec,    blue: flo_s4};
				h2r_pkg::SECT_Y_G: rgb_s5 <= '{red: sec,    green: val_s4, blue: flo_s4};
				h2r_pkg::SECT_G_C: rgb_s5 <= '{red: flo_s4, green: val_s4, blue: sec};
				h2r_pkg::SECT_C_B: rgb_s5 <= '{red: flo_s4, green: sec,    blue: val_s4};
				h2r_pkg::SECT_B_M: rgb_s5 <= '{red: sec,    green: flo_s4, blue: val_s4};
				default:           rgb_s5 <= '{red: val_s4, green: flo_s4, blue: sec};
			endcase
		end
	end

	assign done = v_s5;
	assign rgb  = rgb_s5;

endmodule
`default_nettype wire
